// File: sv/triangle_box_uv_projection_assert.svh
// Assertion macros shared by the triangle_box_uv_projection RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef TRIANGLE_BOX_UV_PROJECTION_ASSERT_SVH
`define TRIANGLE_BOX_UV_PROJECTION_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define TBUV_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tbuv: invariant violated");

// Same-cycle implication.
`define TBUV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbuv: implication violated");

// Next-cycle implication.
`define TBUV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbuv: next-cycle implication violated");

`endif

// File: sv/tbuv_pkg.sv
// Shared widths, codes and item types for the box UV projection block.
// No dependencies; used by every module of the block.
package tbuv_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned SCALE_W    = 32;
  localparam int unsigned SCALE_FRAC = 16;
  localparam int unsigned NUM_VERTS  = 3;

  localparam logic [SCALE_W-1:0] INV_SCALE_RESET = SCALE_W'(1311);

  // Edge vectors, cross products and normal components.
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned CROSS_W = 2 * DIFF_W;
  localparam int unsigned NORM_W  = CROSS_W + 1;

  // Scaling path: coordinate times unsigned scale, rounded, negated.
  localparam int unsigned PROD_W = COORD_W + SCALE_W + 1;
  localparam int unsigned SCL_W  = PROD_W - SCALE_FRAC;
  localparam int unsigned NEG_W  = SCL_W + 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [1:0] face_t;

  localparam face_t FACE_UP    = 2'd0;
  localparam face_t FACE_FWD   = 2'd1;
  localparam face_t FACE_RIGHT = 2'd2;

  typedef struct packed {
    coord_t [NUM_VERTS-1:0] x;
    coord_t [NUM_VERTS-1:0] y;
    coord_t [NUM_VERTS-1:0] z;
  } tri_t;

  typedef struct packed {
    tri_t  verts;
    face_t facing;
    logic  flip;
  } item_t;

  typedef struct packed {
    coord_t [NUM_VERTS-1:0] u;
    coord_t [NUM_VERTS-1:0] v;
    face_t                  facing;
  } result_t;

endpackage

// File: sv/triangle_box_uv_projection.sv
// Top level of the per-triangle box UV projection block.
// Depends on tbuv_pkg, tbuv_front, tbuv_queue and tbuv_back.
//
// The block takes one triangle per clock cycle while busy is low and gives one
// result per triangle, in order, after the triangle has passed the front normal
// pipeline, one queue slot and the three scaling stages. The result is shown
// for exactly one cycle with out_valid, and the receiver cannot stall it, so
// busy stays low in normal operation and would rise only if the two-entry
// queue between the normal pipeline and the scaling stages ever filled. The
// texture scale register is written through the cfg channel, which is always
// ready, and must be written only while no triangle is in flight.
module triangle_box_uv_projection (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tbuv_pkg::COORD_W-1:0] in_a_x,
  input  logic signed [tbuv_pkg::COORD_W-1:0] in_a_y,
  input  logic signed [tbuv_pkg::COORD_W-1:0] in_a_z,
  input  logic signed [tbuv_pkg::COORD_W-1:0] in_b_x,
  input  logic signed [tbuv_pkg::COORD_W-1:0] in_b_y,
  input  logic signed [tbuv_pkg::COORD_W-1:0] in_b_z,
  input  logic signed [tbuv_pkg::COORD_W-1:0] in_c_x,
  input  logic signed [tbuv_pkg::COORD_W-1:0] in_c_y,
  input  logic signed [tbuv_pkg::COORD_W-1:0] in_c_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tbuv_pkg::SCALE_W-1:0]        cfg_inv_scale,
  output logic                               out_valid,
  output logic signed [tbuv_pkg::COORD_W-1:0] out_a_u,
  output logic signed [tbuv_pkg::COORD_W-1:0] out_a_v,
  output logic signed [tbuv_pkg::COORD_W-1:0] out_b_u,
  output logic signed [tbuv_pkg::COORD_W-1:0] out_b_v,
  output logic signed [tbuv_pkg::COORD_W-1:0] out_c_u,
  output logic signed [tbuv_pkg::COORD_W-1:0] out_c_v,
  output logic [1:0]                          out_facing
);

  logic [tbuv_pkg::SCALE_W-1:0] inv_scale_r, inv_scale_nxt;
  tbuv_pkg::tri_t    tri_in;
  tbuv_pkg::item_t   q_wr_item, q_rd_item;
  tbuv_pkg::result_t res;
  logic              q_wr, q_ready, q_valid, q_rd;

  assign cfg_ready     = 1'b1;
  assign inv_scale_nxt = (cfg_valid && cfg_ready) ? cfg_inv_scale : inv_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_scale_r <= tbuv_pkg::INV_SCALE_RESET;
    end else begin
      inv_scale_r <= inv_scale_nxt;
    end
  end

  assign tri_in.x[0] = in_a_x;
  assign tri_in.y[0] = in_a_y;
  assign tri_in.z[0] = in_a_z;
  assign tri_in.x[1] = in_b_x;
  assign tri_in.y[1] = in_b_y;
  assign tri_in.z[1] = in_b_z;
  assign tri_in.x[2] = in_c_x;
  assign tri_in.y[2] = in_c_y;
  assign tri_in.z[2] = in_c_z;

  tbuv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (start),
    .busy_o    (busy),
    .tri_i     (tri_in),
    .q_ready_i (q_ready),
    .q_wr_o    (q_wr),
    .q_item_o  (q_wr_item)
  );

  tbuv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_i      (q_wr),
    .wr_item_i (q_wr_item),
    .ready_o   (q_ready),
    .valid_o   (q_valid),
    .rd_item_o (q_rd_item),
    .rd_i      (q_rd)
  );

  tbuv_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .inv_scale_i (inv_scale_r),
    .q_valid_i   (q_valid),
    .q_item_i    (q_rd_item),
    .q_rd_o      (q_rd),
    .out_valid_o (out_valid),
    .out_o       (res)
  );

  assign out_a_u    = res.u[0];
  assign out_a_v    = res.v[0];
  assign out_b_u    = res.u[1];
  assign out_b_v    = res.v[1];
  assign out_c_u    = res.u[2];
  assign out_c_v    = res.v[2];
  assign out_facing = res.facing;

endmodule

// File: sv/tbuv_front.sv
// Front part: accepts triangles, forms the face normal and picks the axis.
// Depends on tbuv_pkg; feeds tbuv_queue.
module tbuv_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  output logic             busy_o,
  input  tbuv_pkg::tri_t   tri_i,
  input  logic             q_ready_i,
  output logic             q_wr_o,
  output tbuv_pkg::item_t  q_item_o
);

  localparam int unsigned DW = tbuv_pkg::DIFF_W;
  localparam int unsigned CW = tbuv_pkg::CROSS_W;
  localparam int unsigned NW = tbuv_pkg::NORM_W;

  logic adv;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, s4_v_nxt, s5_v_nxt;

  tbuv_pkg::tri_t s1_tri_r, s2_tri_r, s3_tri_r, s4_tri_r;
  logic signed [DW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [CW-1:0] pyz_r, pzy_r, pzx_r, pxz_r, pxy_r, pyx_r;
  logic signed [NW-1:0] nx_r, ny_r, nz_r;
  logic [NW-1:0]        ax_r, ay_r, az_r;
  logic                 nx_neg_r;
  tbuv_pkg::item_t      s5_item_r;

  logic                 x_nz, z_win, y_win;
  tbuv_pkg::face_t      face_sel;

  // The whole front pipeline stalls only when its last item cannot enter the queue.
  assign adv    = !s5_v_r || q_ready_i;
  assign busy_o = !adv;
  assign q_wr_o = s5_v_r && q_ready_i;
  assign q_item_o = s5_item_r;

  assign s1_v_nxt = adv ? start_i : s1_v_r;
  assign s2_v_nxt = adv ? s1_v_r  : s2_v_r;
  assign s3_v_nxt = adv ? s2_v_r  : s3_v_r;
  assign s4_v_nxt = adv ? s3_v_r  : s4_v_r;
  assign s5_v_nxt = adv ? s4_v_r  : s5_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
      s4_v_r <= s4_v_nxt;
      s5_v_r <= s5_v_nxt;
    end
  end

  always_comb begin
    x_nz  = |ax_r;
    z_win = az_r > ax_r;
    y_win = z_win ? (ay_r > az_r) : (ay_r > ax_r);
    if (y_win) begin
      face_sel = tbuv_pkg::FACE_UP;
    end else if (z_win) begin
      face_sel = tbuv_pkg::FACE_FWD;
    end else if (x_nz) begin
      face_sel = tbuv_pkg::FACE_RIGHT;
    end else begin
      face_sel = tbuv_pkg::FACE_UP;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tri_r <= tri_i;
      e1x_r <= DW'($signed(tri_i.x[1])) - DW'($signed(tri_i.x[0]));
      e1y_r <= DW'($signed(tri_i.y[1])) - DW'($signed(tri_i.y[0]));
      e1z_r <= DW'($signed(tri_i.z[1])) - DW'($signed(tri_i.z[0]));
      e2x_r <= DW'($signed(tri_i.x[2])) - DW'($signed(tri_i.x[0]));
      e2y_r <= DW'($signed(tri_i.y[2])) - DW'($signed(tri_i.y[0]));
      e2z_r <= DW'($signed(tri_i.z[2])) - DW'($signed(tri_i.z[0]));

      s2_tri_r <= s1_tri_r;
      pyz_r <= e1y_r * e2z_r;
      pzy_r <= e1z_r * e2y_r;
      pzx_r <= e1z_r * e2x_r;
      pxz_r <= e1x_r * e2z_r;
      pxy_r <= e1x_r * e2y_r;
      pyx_r <= e1y_r * e2x_r;

      s3_tri_r <= s2_tri_r;
      nx_r <= NW'(pyz_r) - NW'(pzy_r);
      ny_r <= NW'(pzx_r) - NW'(pxz_r);
      nz_r <= NW'(pxy_r) - NW'(pyx_r);

      s4_tri_r <= s3_tri_r;
      ax_r <= nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
      ay_r <= ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
      az_r <= nz_r[NW-1] ? NW'(-nz_r) : NW'(nz_r);
      nx_neg_r <= nx_r[NW-1];

      // A negative x component is always nonzero, so the flip needs no further test.
      s5_item_r.verts  <= s4_tri_r;
      s5_item_r.facing <= face_sel;
      s5_item_r.flip   <= nx_neg_r;
    end
  end

endmodule

// File: sv/tbuv_queue.sv
// Short item queue between the front and back parts.
// Depends on tbuv_pkg and the shared assertion macro header.
`include "triangle_box_uv_projection_assert.svh"

module tbuv_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_i,
  input  tbuv_pkg::item_t  wr_item_i,
  output logic             ready_o,
  output logic             valid_o,
  output tbuv_pkg::item_t  rd_item_o,
  input  logic             rd_i
);

  localparam int unsigned DEPTH = tbuv_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = tbuv_pkg::QPTR_W;
  localparam int unsigned QW    = tbuv_pkg::QCNT_W;

  tbuv_pkg::item_t slot_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QW-1:0]   count_r, count_nxt;
  logic            full;

  assign full      = count_r == QW'(DEPTH);
  assign valid_o   = count_r != '0;
  assign ready_o   = !full || rd_i;
  assign rd_item_o = slot_r[rp_r];

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r;
    if (wr_i) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (rd_i) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (wr_i && !rd_i) begin
      count_nxt = count_r + QW'(1);
    end else if (rd_i && !wr_i) begin
      count_nxt = count_r - QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i) begin
      slot_r[wp_r] <= wr_item_i;
    end
  end

  `TBUV_ASSERT_ALWAYS(a_count_bound, count_r <= QW'(DEPTH))
  `TBUV_ASSERT_IMP(a_no_overflow, wr_i, !full || rd_i)
  `TBUV_ASSERT_IMP(a_no_underflow, rd_i, count_r != '0)
  `TBUV_ASSERT_NXT(a_count_up, wr_i && !rd_i, count_r == $past(count_r) + QW'(1))

endmodule

// File: sv/tbuv_back.sv
// Back part: projects the vertices, scales, rounds, negates and saturates.
// Depends on tbuv_pkg; drains tbuv_queue one item per cycle.
module tbuv_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tbuv_pkg::SCALE_W-1:0]  inv_scale_i,
  input  logic                          q_valid_i,
  input  tbuv_pkg::item_t               q_item_i,
  output logic                          q_rd_o,
  output logic                          out_valid_o,
  output tbuv_pkg::result_t             out_o
);

  localparam int unsigned NV  = tbuv_pkg::NUM_VERTS;
  localparam int unsigned CW  = tbuv_pkg::COORD_W;
  localparam int unsigned SW  = tbuv_pkg::SCALE_W;
  localparam int unsigned PW  = tbuv_pkg::PROD_W;
  localparam int unsigned LW  = tbuv_pkg::SCL_W;
  localparam int unsigned GW  = tbuv_pkg::NEG_W;
  localparam int unsigned SF  = tbuv_pkg::SCALE_FRAC;
  localparam logic signed [PW-1:0] RND = PW'(2 ** (SF - 1));
  localparam tbuv_pkg::coord_t CMAX = {1'b0, {(CW - 1){1'b1}}};
  localparam tbuv_pkg::coord_t CMIN = {1'b1, {(CW - 1){1'b0}}};

  function automatic tbuv_pkg::coord_t sat(input logic signed [GW-1:0] w);
    logic [GW-CW:0] hi;
    hi = w[GW-1:CW-1];
    if (&hi || ~|hi) begin
      sat = w[CW-1:0];
    end else begin
      sat = w[GW-1] ? CMIN : CMAX;
    end
  endfunction

  logic b1_v_r, b2_v_r, b3_v_r;
  logic b1_v_nxt, b2_v_nxt, b3_v_nxt;

  logic signed [SW:0]    sc;
  tbuv_pkg::coord_t      p_sel [NV];
  tbuv_pkg::coord_t      q_sel [NV];

  logic signed [PW-1:0]  pu_r [NV];
  logic signed [PW-1:0]  pv_r [NV];
  logic signed [PW-1:0]  ru [NV];
  logic signed [PW-1:0]  rv [NV];
  logic signed [LW-1:0]  su_r [NV];
  logic signed [LW-1:0]  sv_r [NV];
  logic signed [GW-1:0]  wu [NV];
  logic signed [GW-1:0]  wv [NV];
  logic                  b1_flip_r, b2_flip_r;
  tbuv_pkg::face_t       b1_face_r, b2_face_r;
  tbuv_pkg::result_t     out_r;

  assign q_rd_o      = q_valid_i;
  assign sc          = $signed({1'b0, inv_scale_i});
  assign out_valid_o = b3_v_r;
  assign out_o       = out_r;

  assign b1_v_nxt = q_valid_i;
  assign b2_v_nxt = b1_v_r;
  assign b3_v_nxt = b2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
    end else begin
      b1_v_r <= b1_v_nxt;
      b2_v_r <= b2_v_nxt;
      b3_v_r <= b3_v_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      case (q_item_i.facing)
        tbuv_pkg::FACE_RIGHT: begin
          p_sel[i] = q_item_i.verts.x[i];
          q_sel[i] = q_item_i.verts.y[i];
        end
        tbuv_pkg::FACE_FWD: begin
          p_sel[i] = q_item_i.verts.z[i];
          q_sel[i] = q_item_i.verts.y[i];
        end
        default: begin
          p_sel[i] = q_item_i.verts.x[i];
          q_sel[i] = q_item_i.verts.z[i];
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      ru[i] = pu_r[i] + RND;
      rv[i] = pv_r[i] + RND;
      wu[i] = b2_flip_r ? -GW'(su_r[i]) : GW'(su_r[i]);
      wv[i] = -GW'(sv_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NV; i++) begin
      pu_r[i] <= p_sel[i] * sc;
      pv_r[i] <= q_sel[i] * sc;
      su_r[i] <= $signed(ru[i][PW-1:SF]);
      sv_r[i] <= $signed(rv[i][PW-1:SF]);
      out_r.u[i] <= sat(wu[i]);
      out_r.v[i] <= sat(wv[i]);
    end
    b1_flip_r    <= q_item_i.flip;
    b1_face_r    <= q_item_i.facing;
    b2_flip_r    <= b1_flip_r;
    b2_face_r    <= b1_face_r;
    out_r.facing <= b2_face_r;
  end

endmodule
